[hdl/eot_pkg.sv]
`timescale 1ns / 1ps

package eot_pkg;

  typedef enum logic [2:0] {
    PH_START,
    PH_VALUE,
    PH_ESCAPE,
    PH_GAP,
    PH_FAILED
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_END,
    KIND_ERROR
  } kind_t;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_SEP  = 2'd1;
  localparam logic [1:0] ERR_ESC  = 2'd2;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_EOT  = 1'b1;

  localparam logic [1:0] REG_SPACE_A = 2'd0;
  localparam logic [1:0] REG_SPACE_B = 2'd1;
  localparam logic [1:0] REG_SPACE_C = 2'd2;
  localparam logic [1:0] REG_SPACE_D = 2'd3;

  localparam logic [7:0] SPACE_A_RST = 8'd32;
  localparam logic [7:0] SPACE_B_RST = 8'd9;
  localparam logic [7:0] SPACE_C_RST = 8'd12;
  localparam logic [7:0] SPACE_D_RST = 8'd11;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_LETTER_T  = 8'h74;
  localparam logic [7:0] CH_LETTER_F  = 8'h66;
  localparam logic [7:0] CH_LETTER_V  = 8'h76;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_FORMFEED  = 8'h0C;
  localparam logic [7:0] CH_VTAB      = 8'h0B;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] d;
  } sep_set_t;

  typedef struct packed {
    phase_t phase;
    logic   nonempty;
  } parse_state_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] ch;
    logic [1:0] err;
  } result_t;

endpackage

[hdl/eot_cfg_regs.sv]
`timescale 1ns / 1ps

module eot_cfg_regs
  import eot_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output sep_set_t    seps
);

  sep_set_t seps_r;
  logic     wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign seps   = seps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seps_r.a <= SPACE_A_RST;
      seps_r.b <= SPACE_B_RST;
      seps_r.c <= SPACE_C_RST;
      seps_r.d <= SPACE_D_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_SPACE_A: seps_r.a <= pwdata[7:0];
        REG_SPACE_B: seps_r.b <= pwdata[7:0];
        REG_SPACE_C: seps_r.c <= pwdata[7:0];
        REG_SPACE_D: seps_r.d <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SPACE_A: prdata = {24'd0, seps_r.a};
      REG_SPACE_B: prdata = {24'd0, seps_r.b};
      REG_SPACE_C: prdata = {24'd0, seps_r.c};
      REG_SPACE_D: prdata = {24'd0, seps_r.d};
      default:     prdata = 32'd0;
    endcase
  end

endmodule

[hdl/eot_step.sv]
`timescale 1ns / 1ps

module eot_step
  import eot_pkg::*;
(
  input  parse_state_t cur,
  input  logic         opcode,
  input  logic [7:0]   ch,
  input  sep_set_t     seps,
  output parse_state_t nxt,
  output result_t      res
);

  logic is_sep;

  assign is_sep = (ch == seps.a) || (ch == seps.b) || (ch == seps.c) || (ch == seps.d);

  always_comb begin
    nxt       = cur;
    res.valid = 1'b0;
    res.kind  = KIND_CHAR;
    res.ch    = 8'd0;
    res.err   = ERR_NONE;

    if (opcode == OP_EOT) begin
      nxt.phase    = PH_START;
      nxt.nonempty = 1'b0;
      if ((cur.phase != PH_FAILED) && cur.nonempty) begin
        res.valid = 1'b1;
        res.kind  = KIND_END;
      end
    end else if (cur.phase != PH_FAILED) begin
      if (ch == CH_BACKSLASH) begin
        // backslash wins even when it is also a separator
        if (cur.phase == PH_ESCAPE) begin
          res.valid = 1'b1;
          res.ch    = CH_BACKSLASH;
        end else begin
          nxt.phase = PH_ESCAPE;
        end
      end else if (is_sep) begin
        if (cur.phase == PH_VALUE) begin
          nxt.phase    = PH_GAP;
          nxt.nonempty = 1'b0;
          res.valid    = 1'b1;
          res.kind     = KIND_END;
        end else if (cur.phase == PH_ESCAPE) begin
          res.valid = 1'b1;
          if (ch == CH_SPACE) begin
            res.ch = CH_SPACE;
          end else begin
            res.kind = KIND_ERROR;
            res.err  = ERR_SEP;
          end
        end
      end else if (cur.phase == PH_ESCAPE) begin
        res.valid = 1'b1;
        case (ch)
          CH_LETTER_T: res.ch = CH_TAB;
          CH_LETTER_F: res.ch = CH_FORMFEED;
          CH_LETTER_V: res.ch = CH_VTAB;
          default: begin
            res.kind = KIND_ERROR;
            res.err  = ERR_ESC;
          end
        endcase
      end else begin
        res.valid = 1'b1;
        res.ch    = ch;
      end

      // any emitted character lands in a token, an error parks the parser
      if (res.valid && (res.kind == KIND_CHAR)) begin
        nxt.phase    = PH_VALUE;
        nxt.nonempty = 1'b1;
      end else if (res.valid && (res.kind == KIND_ERROR)) begin
        nxt.phase = PH_FAILED;
      end
    end
  end

endmodule

[hdl/escaped_option_tokenizer.sv]
`timescale 1ns / 1ps

// Whitespace tokenizer with backslash escapes. Takes one byte or end-of-text
// mark per cycle and returns at most one result (token character, token end
// or error) in the cycle after the transfer, from an output register. Every
// cycle a new item is taken unless the output register holds an untaken
// result while out_stall is high; the parser state update is a single
// compare-and-select step, so the rate is one item per clock. The four
// separator bytes sit behind the APB-style port and should be written while
// no items are in flight.
module escaped_option_tokenizer
  import eot_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [7:0]  in_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_char,
  output logic [1:0]  out_error_code,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sep_set_t     seps;
  parse_state_t state_r, state_nxt;
  result_t      res;
  logic         accept;
  logic         out_valid_r;
  kind_t        out_kind_r;
  logic [7:0]   out_char_r;
  logic [1:0]   out_err_r;

  eot_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .seps    (seps)
  );

  eot_step u_step (
    .cur    (state_r),
    .opcode (in_opcode),
    .ch     (in_char),
    .seps   (seps),
    .nxt    (state_nxt),
    .res    (res)
  );

  // hold off input only while a result is parked and downstream is stalled
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase    <= PH_START;
      state_r.nonempty <= 1'b0;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!in_stall) begin
      out_valid_r <= accept && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.valid) begin
      out_kind_r <= res.kind;
      out_char_r <= res.ch;
      out_err_r  <= res.err;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_char       = out_char_r;
  assign out_error_code = out_err_r;

endmodule
